/* sv/tusg_pkg.sv */
// tusg_pkg: shared types, constants and helpers of the segmentation header generator
// no dependencies; compiled before the interfaces and modules
`default_nettype none

package tusg_pkg;

  // fixed header sizes and protocol codes
  localparam int unsigned ETH_HEADER_BYTES = 14;
  localparam int unsigned UDP_HDR_BYTES    = 8;
  localparam int unsigned MAX_SEGS         = 48;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // flag masks: cwr survives only on the first segment, psh and fin only on the last
  localparam logic [7:0] KEEP_NOT_FIRST = 8'h7f;
  localparam logic [7:0] KEEP_NOT_LAST  = 8'hf6;

  // field widths
  localparam int unsigned MTU_W   = 14;
  localparam int unsigned FLEN_W  = 17;
  localparam int unsigned PLEN_W  = 14;
  localparam int unsigned IPLEN_W = 16;
  localparam int unsigned OFF_W   = 8;
  localparam int unsigned SUB_W   = 20;

  localparam logic [MTU_W-1:0] MTU_RESET = 14'd8984;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_UDP  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // one result as held in the output register
  typedef struct packed {
    kind_t              kind;
    logic [FLEN_W-1:0]  payload_src_offset;
    logic [PLEN_W-1:0]  payload_len;
    logic [FLEN_W-1:0]  out_frame_len;
    logic [IPLEN_W-1:0] ip_total_len;
    logic [31:0]        seq_out;
    logic [7:0]         flags_out;
    logic [15:0]        udp_len_out;
    logic               last;
  } result_t;

  // operands and outcome of the shared subtract unit
  typedef struct packed {
    logic [SUB_W-1:0] a;
    logic [SUB_W-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic [SUB_W-1:0] diff;
    logic             borrow;
    logic             zero;
  } sub_rsp_t;

  // single result for pass through or header error
  function automatic result_t single_result(kind_t k, logic [FLEN_W-1:0] flen);
    result_t r;
    r                    = '0;
    r.kind               = k;
    r.out_frame_len      = flen;
    r.last               = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/tusg_in_if.sv */
// tusg_in_if: request channel carrying the header fields of one frame
// depends on nothing; valid/ready handshake
`default_nettype none

interface tusg_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] frame_bytes;
  logic [15:0] eth_type;
  logic [3:0]  ip_header_words;
  logic [7:0]  ip_protocol;
  logic [3:0]  tcp_data_offset;
  logic [31:0] tcp_seq;
  logic [7:0]  tcp_flags;
  logic [15:0] udp_length;

  modport source (
    output valid, frame_bytes, eth_type, ip_header_words, ip_protocol,
           tcp_data_offset, tcp_seq, tcp_flags, udp_length,
    input  ready
  );

  modport sink (
    input  valid, frame_bytes, eth_type, ip_header_words, ip_protocol,
           tcp_data_offset, tcp_seq, tcp_flags, udp_length,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tusg_out_if.sv */
// tusg_out_if: result channel carrying one segment header (or pass/error result) per transfer
// depends on nothing; valid/ready handshake
`default_nettype none

interface tusg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [16:0] payload_src_offset;
  logic [13:0] payload_len;
  logic [16:0] out_frame_len;
  logic [15:0] ip_total_len;
  logic [31:0] seq_out;
  logic [7:0]  flags_out;
  logic [15:0] udp_len_out;
  logic        last;

  modport source (
    output valid, kind, payload_src_offset, payload_len, out_frame_len,
           ip_total_len, seq_out, flags_out, udp_len_out, last,
    input  ready
  );

  modport sink (
    input  valid, kind, payload_src_offset, payload_len, out_frame_len,
           ip_total_len, seq_out, flags_out, udp_len_out, last,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tusg_sub.sv */
// tusg_sub: shared subtract/compare unit used by every step of the sequencer
// depends on tusg_pkg
`default_nettype none

module tusg_sub
  import tusg_pkg::*;
(
  input  sub_req_t req,
  output sub_rsp_t rsp
);

  logic [SUB_W:0] wide;

  // a - b with borrow out and zero detect
  assign wide       = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff   = wide[SUB_W-1:0];
  assign rsp.borrow = wide[SUB_W];
  assign rsp.zero   = (wide == '0);

endmodule

`default_nettype wire

/* sv/tcp_udp_segmentation_header_gen_core.sv */
// tcp_udp_segmentation_header_gen_core: splits an oversized ipv4 tcp/udp frame
// into mtu-sized segment headers; depends on tusg_pkg, tusg_in_if, tusg_out_if, tusg_sub
//
//  channel   dir  handshake    contents
//  hdr       in   valid/ready  frame_bytes, eth_type, header sizes, seq, flags, udp_length
//  res       out  valid/ready  one segment header (or pass/error) per response
//  cfg       in   cfg_we       mtu register, 14 bits
//
// a request is accepted in the idle state and takes up to five subtractor steps (pass
// check, mss, udp end, remaining bytes, segment count bound), then one emit step per
// segment result. a pass result, a header error at the mss step or a count error ends
// the request early; a udp request with no payload gives no result at all.
// hdr.ready is high only while the sequencer is idle; a held result stalls the
// sequencer in place. rst is synchronous: mtu returns to 8984, no result pending.
`default_nettype none

module tcp_udp_segmentation_header_gen_core
  import tusg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [MTU_W-1:0] cfg_data,
  tusg_in_if.sink               hdr,
  tusg_out_if.source            res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_MSS,
    S_END,
    S_REM,
    S_CNT,
    S_EMIT
  } state_t;

  state_t state;

  logic [MTU_W-1:0]  mtu;

  // captured request
  logic [FLEN_W-1:0] frame_bytes;
  logic              is_ipv4;
  logic              is_tcp;
  logic              is_udp;
  logic [3:0]        ip_words;
  logic [3:0]        tcp_words;
  logic [31:0]       seq;
  logic [7:0]        flags;
  logic [15:0]       udp_length;

  // working registers
  logic [OFF_W-1:0]  pay_off;
  logic [FLEN_W-1:0] udp_end;
  logic [FLEN_W-1:0] seg_end;
  logic [MTU_W-1:0]  mss;
  logic [SUB_W-1:0]  mss48;
  logic [FLEN_W-1:0] rem;
  logic [FLEN_W-1:0] pos;
  logic              first;

  logic              out_valid;
  result_t           out_r;

  sub_req_t          sreq;
  sub_rsp_t          srsp;

  logic              out_free;
  logic              out_load;
  logic              seg_last;
  logic [PLEN_W-1:0] seg;
  logic [7:0]        seg_flags;
  logic [OFF_W-1:0]  l4_off;
  result_t           seg_res;

  tusg_sub u_sub (
    .req (sreq),
    .rsp (srsp)
  );

  assign out_free = !out_valid || res.ready;
  assign l4_off   = OFF_W'(ETH_HEADER_BYTES) + {2'b00, ip_words, 2'b00};

  // operand select for the shared subtractor
  always_comb begin
    sreq = '0;
    unique case (state)
      S_PASS: begin
        sreq.a = SUB_W'(mtu);
        sreq.b = SUB_W'(frame_bytes);
      end
      S_MSS: begin
        sreq.a = SUB_W'(mtu);
        sreq.b = SUB_W'(pay_off);
      end
      S_END: begin
        sreq.a = SUB_W'(frame_bytes);
        sreq.b = SUB_W'(udp_end);
      end
      S_REM: begin
        sreq.a = SUB_W'(seg_end);
        sreq.b = SUB_W'(pay_off);
      end
      S_CNT: begin
        sreq.a = mss48;
        sreq.b = SUB_W'(rem);
      end
      S_EMIT: begin
        sreq.a = SUB_W'(rem);
        sreq.b = SUB_W'(mss);
      end
      default: begin
        sreq = '0;
      end
    endcase
  end

  // output slot gets a new result this cycle
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      S_PASS: begin
        out_load = out_free && (!srsp.borrow || !is_ipv4 || !(is_tcp || is_udp));
      end
      S_MSS: begin
        out_load = out_free && (srsp.borrow || srsp.zero);
      end
      S_CNT: begin
        out_load = out_free && srsp.borrow;
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // one segment: remaining bytes at or below mss close the request
  always_comb begin
    seg_last  = srsp.borrow || srsp.zero;
    seg       = seg_last ? rem[PLEN_W-1:0] : mss;
    seg_flags = flags;
    if (!first) begin
      seg_flags = seg_flags & KEEP_NOT_FIRST;
    end
    if (!seg_last) begin
      seg_flags = seg_flags & KEEP_NOT_LAST;
    end
    seg_res                    = '0;
    seg_res.kind               = is_tcp ? KIND_TCP : KIND_UDP;
    seg_res.payload_src_offset = pos;
    seg_res.payload_len        = seg;
    seg_res.out_frame_len      = FLEN_W'(pay_off) + FLEN_W'(seg);
    seg_res.ip_total_len       = IPLEN_W'(pay_off - OFF_W'(ETH_HEADER_BYTES))
                                 + IPLEN_W'(seg);
    seg_res.last               = seg_last;
    if (is_tcp) begin
      seg_res.seq_out   = seq;
      seg_res.flags_out = seg_flags;
    end else begin
      seg_res.udp_len_out = 16'(seg) + 16'(UDP_HDR_BYTES);
    end
  end

  // sequencer, registers and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mtu       <= MTU_RESET;
    end else begin
      if (cfg_we) begin
        mtu <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (hdr.valid) begin
            frame_bytes <= hdr.frame_bytes;
            is_ipv4     <= (hdr.eth_type == ETHERTYPE_IPV4);
            is_tcp      <= (hdr.ip_protocol == PROTO_TCP);
            is_udp      <= (hdr.ip_protocol == PROTO_UDP);
            ip_words    <= hdr.ip_header_words;
            tcp_words   <= hdr.tcp_data_offset;
            seq         <= hdr.tcp_seq;
            flags       <= hdr.tcp_flags;
            udp_length  <= hdr.udp_length;
            state       <= S_PASS;
          end
        end
        S_PASS: begin
          pay_off <= l4_off + (is_tcp ? {2'b00, tcp_words, 2'b00}
                                      : OFF_W'(UDP_HDR_BYTES));
          udp_end <= FLEN_W'(l4_off) + FLEN_W'(udp_length);
          if (!srsp.borrow || !is_ipv4 || !(is_tcp || is_udp)) begin
            if (out_free) begin
              out_r <= single_result(KIND_PASS, frame_bytes);
              state <= S_IDLE;
            end
          end else begin
            state <= S_MSS;
          end
        end
        S_MSS: begin
          if (srsp.borrow || srsp.zero) begin
            if (out_free) begin
              out_r <= single_result(KIND_ERR, frame_bytes);
              state <= S_IDLE;
            end
          end else begin
            mss   <= srsp.diff[MTU_W-1:0];
            state <= S_END;
          end
        end
        S_END: begin
          mss48 <= {1'b0, mss, 5'b0} + {2'b00, mss, 4'b0};
          if (is_tcp || srsp.borrow) begin
            seg_end <= frame_bytes;
          end else begin
            seg_end <= udp_end;
          end
          state <= S_REM;
        end
        S_REM: begin
          if (srsp.borrow || srsp.zero) begin
            state <= S_IDLE;
          end else begin
            rem   <= srsp.diff[FLEN_W-1:0];
            pos   <= FLEN_W'(pay_off);
            first <= 1'b1;
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (srsp.borrow) begin
            if (out_free) begin
              out_r <= single_result(KIND_ERR, frame_bytes);
              state <= S_IDLE;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_r <= seg_res;
            first <= 1'b0;
            pos   <= pos + FLEN_W'(seg);
            seq   <= seq + 32'(seg);
            rem   <= srsp.diff[FLEN_W-1:0];
            if (seg_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign hdr.ready              = (state == S_IDLE);
  assign res.valid              = out_valid;
  assign res.kind               = out_r.kind;
  assign res.payload_src_offset = out_r.payload_src_offset;
  assign res.payload_len        = out_r.payload_len;
  assign res.out_frame_len      = out_r.out_frame_len;
  assign res.ip_total_len       = out_r.ip_total_len;
  assign res.seq_out            = out_r.seq_out;
  assign res.flags_out          = out_r.flags_out;
  assign res.udp_len_out        = out_r.udp_len_out;
  assign res.last               = out_r.last;

  // a request is taken only once per idle period
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    hdr.valid && hdr.ready |=> !hdr.ready)
    else $error("request accepted while busy");

  // pass and error results stand alone
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_r.kind == KIND_PASS || out_r.kind == KIND_ERR) |-> out_r.last)
    else $error("pass or error result without last");

  // every segment carries payload
  a_seg_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_r.kind == KIND_TCP || out_r.kind == KIND_UDP)
      |-> out_r.payload_len != '0)
    else $error("empty segment emitted");

  // segments before the last are full mss
  a_seg_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_r.kind == KIND_TCP || out_r.kind == KIND_UDP) && !out_r.last
      |-> out_r.payload_len == mss)
    else $error("short segment before the last");

endmodule

`default_nettype wire

/* sim/tb_tcp_udp_segmentation_header_gen_core.sv */
// tb_tcp_udp_segmentation_header_gen_core: self-checking bench for the segmentation header generator
// depends on tusg_pkg, tusg_in_if, tusg_out_if and tcp_udp_segmentation_header_gen_core
// header requests are predicted on acceptance and every segment result is checked in order
`timescale 1ns / 100ps

module tb_tcp_udp_segmentation_header_gen_core;
  import tusg_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 600000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned HOLDOFF_CYCLES  = 300;
  localparam int unsigned MAX_PRINTED     = 200;
  localparam int unsigned FRAME_BYTES_TOP = 65549;

  // header fields of one request
  typedef struct packed {
    logic [16:0] frame_bytes;
    logic [15:0] eth_type;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [3:0]  tcp_data_offset;
    logic [31:0] tcp_seq;
    logic [7:0]  tcp_flags;
    logic [15:0] udp_length;
  } hdr_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             cfg_we   = 1'b0;
  logic [MTU_W-1:0] cfg_data = '0;

  tusg_in_if  hdr_if ();
  tusg_out_if res_if ();

  tcp_udp_segmentation_header_gen_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .hdr      (hdr_if),
    .res      (res_if)
  );

  hdr_t             hdr_pending_q[$];
  result_t          seg_expect_q[$];
  logic [MTU_W-1:0] mtu_model      = MTU_RESET;
  logic             hdr_took       = 1'b0;
  int unsigned      hdr_queued_cnt = 0;
  int unsigned      hdr_accept_cnt = 0;
  int unsigned      res_seen_cnt   = 0;
  int unsigned      fail_cnt       = 0;
  int unsigned      cycle_cnt      = 0;
  int unsigned      snd_idle_pct   = 0;
  int unsigned      rcv_idle_pct   = 0;
  logic             holdoff_arm    = 1'b0;
  logic             holdoff_used   = 1'b0;
  int unsigned      holdoff_cnt    = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (fail_cnt < MAX_PRINTED) begin
      $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, res_seen_cnt, what, got, want);
    end
    fail_cnt++;
  endtask

  // expected segment headers of one request under the given mtu
  function automatic void expand_segments(hdr_t h, logic [MTU_W-1:0] mtu_val);
    int unsigned flen, l4_off, pay_off, end_off, mss, nseg, pos, seg;
    logic        is_tcp;
    logic [31:0] seq;
    logic [7:0]  flags;
    result_t     r;
    flen   = h.frame_bytes;
    is_tcp = (h.ip_protocol == PROTO_TCP);
    r      = '0;
    r.out_frame_len = h.frame_bytes;
    r.last          = 1'b1;

    // short frame, non-ipv4 or other protocol: single pass-through header
    if (flen <= mtu_val || h.eth_type != ETHERTYPE_IPV4 ||
        (!is_tcp && h.ip_protocol != PROTO_UDP)) begin
      r.kind = KIND_PASS;
      seg_expect_q.push_back(r);
      return;
    end

    l4_off = ETH_HEADER_BYTES + 4 * h.ip_header_words;
    if (is_tcp) begin
      pay_off = l4_off + 4 * h.tcp_data_offset;
      end_off = flen;
    end else begin
      pay_off = l4_off + UDP_HDR_BYTES;
      end_off = (l4_off + h.udp_length < flen) ? l4_off + h.udp_length : flen;
    end

    // headers alone reach the mtu
    r.kind = KIND_ERR;
    if (pay_off >= mtu_val) begin
      seg_expect_q.push_back(r);
      return;
    end
    mss = mtu_val - pay_off;

    // udp datagram with nothing to carry gives no header at all
    if (end_off <= pay_off) return;

    nseg = (end_off - pay_off + mss - 1) / mss;
    if (nseg > MAX_SEGS) begin
      seg_expect_q.push_back(r);
      return;
    end

    // one header per segment, sequence advancing by payload bytes
    pos = pay_off;
    seq = h.tcp_seq;
    for (int unsigned k = 0; k < nseg; k++) begin
      seg                  = (end_off - pos < mss) ? end_off - pos : mss;
      r                    = '0;
      r.payload_src_offset = pos;
      r.payload_len        = seg;
      r.out_frame_len      = pay_off + seg;
      r.ip_total_len       = pay_off - ETH_HEADER_BYTES + seg;
      r.last               = (k + 1 == nseg);
      if (is_tcp) begin
        flags = h.tcp_flags;
        if (k != 0) flags = flags & KEEP_NOT_FIRST;
        if (k + 1 != nseg) flags = flags & KEEP_NOT_LAST;
        r.kind      = KIND_TCP;
        r.seq_out   = seq;
        r.flags_out = flags;
        seq         = seq + seg;
      end else begin
        r.kind        = KIND_UDP;
        r.udp_len_out = seg + UDP_HDR_BYTES;
      end
      seg_expect_q.push_back(r);
      pos += seg;
    end
  endfunction

  // request driver: holds an item until it is taken
  always @(negedge clk) begin
    hdr_t h;
    if (rst) begin
      hdr_if.valid           <= 1'b0;
      hdr_if.frame_bytes     <= '0;
      hdr_if.eth_type        <= '0;
      hdr_if.ip_header_words <= '0;
      hdr_if.ip_protocol     <= '0;
      hdr_if.tcp_data_offset <= '0;
      hdr_if.tcp_seq         <= '0;
      hdr_if.tcp_flags       <= '0;
      hdr_if.udp_length      <= '0;
    end else if (!hdr_if.valid || hdr_took) begin
      if (hdr_pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        h = hdr_pending_q.pop_front();
        hdr_if.valid           <= 1'b1;
        hdr_if.frame_bytes     <= h.frame_bytes;
        hdr_if.eth_type        <= h.eth_type;
        hdr_if.ip_header_words <= h.ip_header_words;
        hdr_if.ip_protocol     <= h.ip_protocol;
        hdr_if.tcp_data_offset <= h.tcp_data_offset;
        hdr_if.tcp_seq         <= h.tcp_seq;
        hdr_if.tcp_flags       <= h.tcp_flags;
        hdr_if.udp_length      <= h.udp_length;
      end else begin
        hdr_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once
  always @(negedge clk) begin
    if (holdoff_arm && !holdoff_used) begin
      holdoff_cnt  <= HOLDOFF_CYCLES;
      holdoff_used <= 1'b1;
    end else if (holdoff_cnt != 0) begin
      holdoff_cnt <= holdoff_cnt - 1;
    end
  end

  // result receiver backpressure
  always @(negedge clk) begin
    res_if.ready <= !rst && holdoff_cnt == 0 && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // monitor: check results in order, predict on each accepted request
  always @(posedge clk) begin
    hdr_t    h;
    result_t got, want;
    hdr_took <= hdr_if.valid && hdr_if.ready && !rst;
    if (rst) begin
      mtu_model = MTU_RESET;
    end else begin
      if (cfg_we) mtu_model = cfg_data;

      if (res_if.valid && res_if.ready) begin
        got.kind               = kind_t'(res_if.kind);
        got.payload_src_offset = res_if.payload_src_offset;
        got.payload_len        = res_if.payload_len;
        got.out_frame_len      = res_if.out_frame_len;
        got.ip_total_len       = res_if.ip_total_len;
        got.seq_out            = res_if.seq_out;
        got.flags_out          = res_if.flags_out;
        got.udp_len_out        = res_if.udp_len_out;
        got.last               = res_if.last;
        res_seen_cnt++;
        if (seg_expect_q.size() == 0) begin
          report_mismatch("result with no request outstanding", got.out_frame_len, 0);
        end else begin
          want = seg_expect_q.pop_front();
          if (got.kind != want.kind)
            report_mismatch("kind", got.kind, want.kind);
          if (got.payload_src_offset != want.payload_src_offset)
            report_mismatch("payload_src_offset", got.payload_src_offset,
                            want.payload_src_offset);
          if (got.payload_len != want.payload_len)
            report_mismatch("payload_len", got.payload_len, want.payload_len);
          if (got.out_frame_len != want.out_frame_len)
            report_mismatch("out_frame_len", got.out_frame_len, want.out_frame_len);
          if (got.ip_total_len != want.ip_total_len)
            report_mismatch("ip_total_len", got.ip_total_len, want.ip_total_len);
          if (got.seq_out != want.seq_out)
            report_mismatch("seq_out", got.seq_out, want.seq_out);
          if (got.flags_out != want.flags_out)
            report_mismatch("flags_out", got.flags_out, want.flags_out);
          if (got.udp_len_out != want.udp_len_out)
            report_mismatch("udp_len_out", got.udp_len_out, want.udp_len_out);
          if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
        end
      end

      if (hdr_if.valid && hdr_if.ready) begin
        h.frame_bytes     = hdr_if.frame_bytes;
        h.eth_type        = hdr_if.eth_type;
        h.ip_header_words = hdr_if.ip_header_words;
        h.ip_protocol     = hdr_if.ip_protocol;
        h.tcp_data_offset = hdr_if.tcp_data_offset;
        h.tcp_seq         = hdr_if.tcp_seq;
        h.tcp_flags       = hdr_if.tcp_flags;
        h.udp_length      = hdr_if.udp_length;
        expand_segments(h, mtu_model);
        hdr_accept_cnt <= hdr_accept_cnt + 1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic hdr_t mk_hdr(int unsigned flen, logic [15:0] etype, logic [3:0] ipw,
                                  logic [7:0] proto, logic [3:0] tcpw, logic [31:0] seq,
                                  logic [7:0] flags, logic [15:0] ulen);
    hdr_t h;
    h.frame_bytes     = flen;
    h.eth_type        = etype;
    h.ip_header_words = ipw;
    h.ip_protocol     = proto;
    h.tcp_data_offset = tcpw;
    h.tcp_seq         = seq;
    h.tcp_flags       = flags;
    h.udp_length      = ulen;
    return h;
  endfunction

  task automatic queue_item(hdr_t h);
    hdr_pending_q.push_back(h);
    hdr_queued_cnt++;
  endtask

  // random requests: mostly well-formed tcp and udp frames, some noise
  task automatic queue_random(int unsigned n, int unsigned mtu_val);
    hdr_t        h;
    int unsigned sel, roll, l4_off, hi;
    hi = (mtu_val * 40 < FRAME_BYTES_TOP) ? mtu_val * 40 : FRAME_BYTES_TOP;
    repeat (n) begin
      sel               = $urandom_range(0, 99);
      h.tcp_seq         = ($urandom_range(0, 9) == 0) ?
                          32'hffff_ffff - $urandom_range(0, 20000) : $urandom;
      h.tcp_flags       = $urandom_range(0, 255);
      h.ip_header_words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      h.tcp_data_offset = ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 15) : $urandom_range(5, 8);

      // frame length: short, segmented, near the top, beyond the top
      roll = $urandom_range(0, 99);
      if (roll < 20)      h.frame_bytes = $urandom_range(0, mtu_val);
      else if (roll < 92) h.frame_bytes = $urandom_range(mtu_val + 1, hi);
      else if (roll < 97) h.frame_bytes = FRAME_BYTES_TOP - $urandom_range(0, 13);
      else                h.frame_bytes = $urandom_range(FRAME_BYTES_TOP + 1, 131071);

      if (sel < 45) begin
        h.eth_type    = ETHERTYPE_IPV4;
        h.ip_protocol = PROTO_TCP;
      end else if (sel < 85) begin
        h.eth_type    = ETHERTYPE_IPV4;
        h.ip_protocol = PROTO_UDP;
      end else if (sel < 92) begin
        h.eth_type    = $urandom_range(0, 65535);
        h.ip_protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      end else begin
        h.eth_type    = ETHERTYPE_IPV4;
        h.ip_protocol = $urandom_range(0, 255);
      end

      // udp length: consistent with the frame, random, or nearly empty
      l4_off = ETH_HEADER_BYTES + 4 * h.ip_header_words;
      roll   = $urandom_range(0, 99);
      if (roll < 70)      h.udp_length = h.frame_bytes - l4_off;
      else if (roll < 85) h.udp_length = $urandom_range(0, 65535);
      else                h.udp_length = $urandom_range(0, 16);
      queue_item(h);
    end
  endtask

  // wait until every request is taken and every header is back
  task automatic drain();
    do @(negedge clk);
    while (hdr_accept_cnt != hdr_queued_cnt || seg_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mtu(logic [MTU_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset mtu: field extremes, every frame class, udp end cases
    @(posedge clk);
    snd_idle_pct = 6;
    rcv_idle_pct = 68;
    queue_item(mk_hdr(0, 16'h0000, 4'd0, 8'd0, 4'd0, 32'h0, 8'h00, 16'h0));
    queue_item(mk_hdr(64, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'h1234_5678, 8'hff, 16'h0));
    queue_item(mk_hdr(8984, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'h1, 8'hff, 16'h0));
    queue_item(mk_hdr(8985, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'h1000, 8'hff, 16'h0));
    queue_item(mk_hdr(17914, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'h0, 8'h89, 16'h0));
    queue_item(mk_hdr(65549, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, 32'hffff_f000, 8'hff,
                      16'hffff));
    queue_item(mk_hdr(65536, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 32'hffff_ffff, 8'h09,
                      16'h0));
    queue_item(mk_hdr(131071, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd8, 32'h8000_0000, 8'h81,
                      16'h0));
    queue_item(mk_hdr(9000, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 4'd0, 32'h5555_aaaa, 8'hff,
                      16'h0));
    queue_item(mk_hdr(20000, 16'h86dd, 4'd5, PROTO_TCP, 4'd5, 32'h0, 8'hff, 16'h0));
    queue_item(mk_hdr(65549, 16'hffff, 4'd15, 8'hff, 4'd15, 32'hffff_ffff, 8'hff, 16'hffff));
    queue_item(mk_hdr(20000, ETHERTYPE_IPV4, 4'd5, 8'd1, 4'd5, 32'h0, 8'h00, 16'h0));
    queue_item(mk_hdr(20000, ETHERTYPE_IPV4, 4'd15, 8'hff, 4'd15, 32'h0, 8'h00, 16'h0));
    queue_item(mk_hdr(30000, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 4'd15, 32'hdead_beef, 8'hff,
                      16'd29966));
    queue_item(mk_hdr(30000, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 4'd0, 32'h0, 8'h00, 16'd12000));
    queue_item(mk_hdr(30000, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 4'd0, 32'h0, 8'h00, 16'hffff));
    queue_item(mk_hdr(30000, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 4'd0, 32'h0, 8'h00, 16'd8));
    queue_item(mk_hdr(30000, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 4'd0, 32'h0, 8'h00, 16'd0));
    queue_item(mk_hdr(9500, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 4'd0, 32'h0, 8'h00, 16'd9));
    queue_item(mk_hdr(65549, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 4'd15, 32'hffff_ffff, 8'hff,
                      16'hffff));
    drain();

    // mtu 1500: segment count at and over its bound
    write_mtu(14'd1500);
    @(posedge clk);
    queue_item(mk_hdr(131071, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, 32'h0, 8'hff, 16'h0));
    queue_item(mk_hdr(65549, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, 32'hffff_0000, 8'hff,
                      16'h0));
    queue_random(110, 1500);
    drain();

    // mtu 9216, sender now the slow side
    write_mtu(14'd9216);
    @(posedge clk);
    snd_idle_pct = 68;
    rcv_idle_pct = 6;
    queue_random(110, 9216);
    drain();

    // tiny mtu: headers reaching the mtu, small segments
    write_mtu(14'd122);
    @(posedge clk);
    queue_item(mk_hdr(5000, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd12, 32'h0, 8'hff, 16'h0));
    queue_item(mk_hdr(310, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd11, 32'hffff_ff00, 8'hff,
                      16'h0));
    queue_item(mk_hdr(311, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd11, 32'h0, 8'hff, 16'h0));
    queue_item(mk_hdr(5000, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 4'd0, 32'h0, 8'h00, 16'hffff));
    queue_random(60, 122);
    drain();

    // all-ones mtu, no idling, one long receiver stall
    write_mtu(14'h3fff);
    @(posedge clk);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    holdoff_arm  = 1'b1;
    queue_random(90, 16383);
    drain();

    // back to the reset value
    write_mtu(MTU_RESET);
    @(posedge clk);
    queue_random(80, MTU_RESET);
    drain();

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
